>>> rtl/core/smh_pkg.sv
`default_nettype none

package smh_pkg;

	localparam int MAX_BINS_DEF = 128;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 32;
	localparam int SUM1_W   = 48;
	localparam int SUM2_W   = 63;
	localparam int SUM3_W   = 64;
	localparam int TOTAL_W  = 32;
	localparam int IDX_W    = 7;
	localparam int CFG_W    = 16;

	// enable_mask bit positions
	localparam int EN_LAST = 0;
	localparam int EN_SUM1 = 1;
	localparam int EN_SUM2 = 2;
	localparam int EN_SUM3 = 3;
	localparam int EN_HIST = 4;

	localparam logic [4:0]        ENABLE_RST    = 5'd31;
	localparam logic signed [15:0] LOW_EDGE_RST = -16'sd1280;
	localparam logic [15:0]       INV_WIDTH_RST = 16'd2560;
	localparam logic [7:0]        BINS_RST      = 8'd100;

	// rounding offset of one half in Q16.16
	localparam logic signed [34:0] HALF_BIN = 35'sd32768;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		REG_ENABLE_MASK,
		REG_RANGE_LOW,
		REG_INV_WIDTH,
		REG_BINS_IN_USE
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/core/streaming_moments_histogram.sv
`default_nettype none

// Running moments and histogram. Each add request bumps a saturating sample
// count and, under enable_mask, records the last sample and adds x, x^2 and
// x^3 into saturating sums; with the histogram enabled it also counts the
// sample in bin floor((x - range_low_edge) * inverse_bin_width + 1/2) when
// that bin is below bins_in_use (limited to MAX_BINS). A read request returns
// the count of one bin. Every request yields one result. The bin counts live
// in a single-port-per-direction RAM; each request passes in turn through
// accept, multiply, bin select and RAM read, update and write back, and
// result load, and the next is taken only once the result is loaded, which
// waits while a previous result still sits in the output register. After
// reset the block clears every RAM entry before it takes a request.

module streaming_moments_histogram import smh_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_wr_en,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,

	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       req_type,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic [IDX_W-1:0]           bin_select,

	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [COUNT_W-1:0]              sample_count,
	output logic signed [SAMPLE_W-1:0]      last_sample,
	output logic signed [SUM1_W-1:0]        sum_linear,
	output logic [SUM2_W-1:0]               sum_squares,
	output logic signed [SUM3_W-1:0]        sum_cubes,
	output logic [IDX_W-1:0]                bin_index,
	output logic                            bin_hit,
	output logic [TOTAL_W-1:0]              bin_total
);

	localparam int AddrW   = $clog2(MAX_BINS);
	localparam int ExtW    = (AddrW > 8) ? AddrW : 8;
	localparam int CapBins = (MAX_BINS > 255) ? 255 : MAX_BINS;
	localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_BINS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_READ,
		ST_UPDATE,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0]          enable_q;
	logic signed [15:0]  low_edge_q;
	logic [15:0]         inv_width_q;
	logic [7:0]          bins_q;

	// accumulators
	logic [COUNT_W-1:0]        count_q;
	logic signed [SAMPLE_W-1:0] last_q;
	logic signed [SUM1_W-1:0]  sum1_q;
	logic [SUM2_W-1:0]         sum2_q;
	logic signed [SUM3_W-1:0]  sum3_q;

	// request in flight
	logic                       req_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [IDX_W-1:0]           sel_q;
	logic signed [34:0]         prod_q;
	logic signed [31:0]         xsq_q;
	logic signed [47:0]         x3_q;
	logic                       hit_q;
	logic [IDX_W-1:0]           idx_q;
	logic [AddrW-1:0]           addr_q;
	logic [TOTAL_W-1:0]         total_q;
	logic [AddrW-1:0]           clr_q;

	// RAM
	logic               ram_we;
	logic [AddrW-1:0]   ram_waddr;
	logic [TOTAL_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AddrW-1:0]   ram_raddr;
	logic [TOTAL_W-1:0] ram_rdata;

	// combinational
	logic signed [16:0] diff;
	logic signed [33:0] mul_bin;
	logic signed [34:0] prod_next;
	logic signed [31:0] sq_next;
	logic signed [47:0] cube_next;
	logic [7:0]         limit;
	logic [18:0]        bin;
	logic               hist_hit;
	logic               sel_hit;
	logic [7:0]         idx8;
	logic [ExtW-1:0]    idx_ext;
	logic               hit_next;
	logic [IDX_W-1:0]   idx_next;
	logic [TOTAL_W-1:0] inc_total;
	logic [TOTAL_W-1:0] total_next;
	logic [COUNT_W-1:0] count_next;
	logic signed [SUM1_W:0] s1;
	logic [SUM2_W:0]    s2;
	logic signed [SUM3_W:0] s3;
	logic [SUM1_W-1:0]  sum1_next;
	logic [SUM2_W-1:0]  sum2_next;
	logic [SUM3_W-1:0]  sum3_next;
	logic               out_free;
	logic               is_add;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;
	assign is_add   = (req_q == REQ_ADD);

	always_comb begin
		diff      = $signed({x_q[15], x_q}) - $signed({low_edge_q[15], low_edge_q});
		mul_bin   = diff * $signed({1'b0, inv_width_q});
		prod_next = $signed({mul_bin[33], mul_bin}) + HALF_BIN;
		sq_next   = x_q * x_q;
		cube_next = xsq_q * x_q;

		limit    = (bins_q > 8'(CapBins)) ? 8'(CapBins) : bins_q;
		bin      = prod_q[34:16];
		hist_hit = enable_q[EN_HIST] && !prod_q[34] && (bin < {11'b0, limit});
		sel_hit  = ({1'b0, sel_q} < limit);

		idx8    = (req_q == REQ_READ) ? {1'b0, sel_q} : bin[7:0];
		idx_ext = ExtW'(idx8);
		if (req_q == REQ_READ) begin
			hit_next = sel_hit;
			idx_next = sel_q;
		end else begin
			hit_next = hist_hit;
			idx_next = hist_hit ? bin[IDX_W-1:0] : '0;
		end

		inc_total = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
		if (!hit_q) begin
			total_next = '0;
		end else if (is_add) begin
			total_next = inc_total;
		end else begin
			total_next = ram_rdata;
		end

		count_next = (count_q == '1) ? count_q : count_q + 1'b1;

		s1 = $signed({sum1_q[SUM1_W-1], sum1_q}) + $signed({{33{x_q[15]}}, x_q});
		if (s1[SUM1_W] != s1[SUM1_W-1]) begin
			sum1_next = s1[SUM1_W] ? {1'b1, {(SUM1_W-1){1'b0}}} : {1'b0, {(SUM1_W-1){1'b1}}};
		end else begin
			sum1_next = s1[SUM1_W-1:0];
		end

		s2 = {1'b0, sum2_q} + {32'b0, xsq_q};
		sum2_next = s2[SUM2_W] ? '1 : s2[SUM2_W-1:0];

		s3 = $signed({sum3_q[SUM3_W-1], sum3_q}) + $signed({{17{x3_q[47]}}, x3_q});
		if (s3[SUM3_W] != s3[SUM3_W-1]) begin
			sum3_next = s3[SUM3_W] ? {1'b1, {(SUM3_W-1){1'b0}}} : {1'b0, {(SUM3_W-1){1'b1}}};
		end else begin
			sum3_next = s3[SUM3_W-1:0];
		end
	end

	// RAM ports: clearing sweep after reset, then write back of the bin count
	always_comb begin
		ram_re    = (state_q == ST_READ);
		ram_raddr = idx_ext[AddrW-1:0];
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_UPDATE) && is_add && hit_q;
			ram_waddr = addr_q;
			ram_wdata = inc_total;
		end
	end

	smh_ram #(
		.WIDTH(TOTAL_W),
		.DEPTH(MAX_BINS)
	) u_bins (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			low_edge_q  <= LOW_EDGE_RST;
			inv_width_q <= INV_WIDTH_RST;
			bins_q      <= BINS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE_MASK: enable_q    <= cfg_data[4:0];
				REG_RANGE_LOW:   low_edge_q  <= $signed(cfg_data);
				REG_INV_WIDTH:   inv_width_q <= cfg_data;
				REG_BINS_IN_USE: bins_q      <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			count_q      <= '0;
			last_q       <= '0;
			sum1_q       <= '0;
			sum2_q       <= '0;
			sum3_q       <= '0;
			req_q        <= REQ_ADD;
			x_q          <= '0;
			sel_q        <= '0;
			prod_q       <= '0;
			xsq_q        <= '0;
			x3_q         <= '0;
			hit_q        <= 1'b0;
			idx_q        <= '0;
			addr_q       <= '0;
			total_q      <= '0;
			out_valid    <= 1'b0;
			sample_count <= '0;
			last_sample  <= '0;
			sum_linear   <= '0;
			sum_squares  <= '0;
			sum_cubes    <= '0;
			bin_index    <= '0;
			bin_hit      <= 1'b0;
			bin_total    <= '0;
		end else begin
			// a result loaded in ST_OUT takes over the output register
			if (out_valid && out_ready && (state_q != ST_OUT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == LastAddr) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						x_q     <= sample_value;
						sel_q   <= bin_select;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= prod_next;
					xsq_q   <= sq_next;
					state_q <= ST_READ;
				end
				ST_READ: begin
					x3_q    <= cube_next;
					hit_q   <= hit_next;
					idx_q   <= idx_next;
					addr_q  <= ram_raddr;
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					total_q <= total_next;
					if (is_add) begin
						count_q <= count_next;
						if (enable_q[EN_LAST]) last_q <= x_q;
						if (enable_q[EN_SUM1]) sum1_q <= sum1_next;
						if (enable_q[EN_SUM2]) sum2_q <= sum2_next;
						if (enable_q[EN_SUM3]) sum3_q <= sum3_next;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						sample_count <= count_q;
						last_sample  <= last_q;
						sum_linear   <= sum1_q;
						sum_squares  <= sum2_q;
						sum_cubes    <= sum3_q;
						bin_index    <= idx_q;
						bin_hit      <= hit_q;
						bin_total    <= total_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/smh_ram.sv
`default_nettype none

module smh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/tb_streaming_moments_histogram.sv
`timescale 1ns / 100ps

module tb_streaming_moments_histogram;
	import smh_pkg::*;

	localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN = -I64_MAX - 1;
	localparam longint SUM1_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM1_MIN = -SUM1_MAX - 1;
	localparam logic [63:0] SUM2_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [SAMPLE_W-1:0] last;
		logic [SUM1_W-1:0]   sum1;
		logic [SUM2_W-1:0]   sum2;
		logic [SUM3_W-1:0]   sum3;
		logic [IDX_W-1:0]    idx;
		logic                hit;
		logic [TOTAL_W-1:0]  total;
	} moments_t;

	typedef struct {
		bit                  is_cfg;
		cfg_reg_t            reg_sel;
		logic [CFG_W-1:0]    cfg_val;
		logic                rt;
		logic [SAMPLE_W-1:0] sv;
		logic [IDX_W-1:0]    sel;
		bit                  typed;
		moments_t            want;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [1:0]                 cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic                       req_type;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [IDX_W-1:0]           bin_select;
	logic                       out_valid;
	logic                       out_ready;
	logic [COUNT_W-1:0]         sample_count;
	logic signed [SAMPLE_W-1:0] last_sample;
	logic signed [SUM1_W-1:0]   sum_linear;
	logic [SUM2_W-1:0]          sum_squares;
	logic signed [SUM3_W-1:0]   sum_cubes;
	logic [IDX_W-1:0]           bin_index;
	logic                       bin_hit;
	logic [TOTAL_W-1:0]         bin_total;

	// predictor copy of the block's registers and state
	logic [4:0]           cfg_enable;
	logic signed [15:0]   cfg_low;
	logic [15:0]          cfg_inv;
	logic [7:0]           cfg_bins;
	logic [COUNT_W-1:0]   acc_count;
	logic [SAMPLE_W-1:0]  acc_last;
	longint               acc_sum1;
	logic [63:0]          acc_sum2;
	longint               acc_sum3;
	logic [TOTAL_W-1:0]   hist_bins [MAX_BINS_DEF];

	moments_t  pending_results [$];
	stim_row_t plan [$];
	moments_t  got_res;
	int        mismatch_cnt = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;

	streaming_moments_histogram u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic moments_t predict_moments(logic rt, logic [SAMPLE_W-1:0] sv,
			logic [IDX_W-1:0] sel);
		moments_t r;
		longint x, s1, sq, cube, prod, bin, lim;
		r = '0;
		lim = (cfg_bins > MAX_BINS_DEF) ? MAX_BINS_DEF : cfg_bins;
		if (rt == REQ_ADD) begin
			x = longint'($signed(sv));
			if (acc_count != '1)
				acc_count++;
			if (cfg_enable[EN_LAST])
				acc_last = sv;
			if (cfg_enable[EN_SUM1]) begin
				s1 = acc_sum1 + x;
				acc_sum1 = (s1 > SUM1_MAX) ? SUM1_MAX : (s1 < SUM1_MIN) ? SUM1_MIN : s1;
			end
			if (cfg_enable[EN_SUM2]) begin
				sq = x * x;
				if (acc_sum2 > SUM2_MAX - sq)
					acc_sum2 = SUM2_MAX;
				else
					acc_sum2 = acc_sum2 + sq;
			end
			if (cfg_enable[EN_SUM3]) begin
				cube = x * x * x;
				if (cube > 0 && acc_sum3 > I64_MAX - cube)
					acc_sum3 = I64_MAX;
				else if (cube < 0 && acc_sum3 < I64_MIN - cube)
					acc_sum3 = I64_MIN;
				else
					acc_sum3 = acc_sum3 + cube;
			end
			if (cfg_enable[EN_HIST]) begin
				// round to nearest bin in Q16.16
				prod = (x - longint'(cfg_low)) * longint'(cfg_inv) + 32768;
				if (prod >= 0) begin
					bin = prod >>> 16;
					if (bin < lim) begin
						if (hist_bins[bin] != '1)
							hist_bins[bin]++;
						r.idx = bin[IDX_W-1:0];
						r.hit = 1'b1;
						r.total = hist_bins[bin];
					end
				end
			end
		end else begin
			r.idx = sel;
			if (longint'(sel) < lim) begin
				r.hit = 1'b1;
				r.total = hist_bins[sel];
			end
		end
		r.count = acc_count;
		r.last = acc_last;
		r.sum1 = acc_sum1[SUM1_W-1:0];
		r.sum2 = acc_sum2[SUM2_W-1:0];
		r.sum3 = acc_sum3;
		return r;
	endfunction

	function automatic void plan_req(logic rt, logic [SAMPLE_W-1:0] sv, logic [IDX_W-1:0] sel);
		stim_row_t row;
		row = '{default: '0, reg_sel: REG_ENABLE_MASK};
		row.rt = rt;
		row.sv = sv;
		row.sel = sel;
		plan.push_back(row);
	endfunction

	function automatic void plan_typed(logic rt, logic [SAMPLE_W-1:0] sv, logic [IDX_W-1:0] sel,
			moments_t want);
		plan_req(rt, sv, sel);
		plan[$].typed = 1'b1;
		plan[$].want = want;
	endfunction

	function automatic void plan_cfg(cfg_reg_t r, logic [CFG_W-1:0] v);
		stim_row_t row;
		row = '{default: '0, reg_sel: REG_ENABLE_MASK};
		row.is_cfg = 1'b1;
		row.reg_sel = r;
		row.cfg_val = v;
		plan.push_back(row);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(logic rt, logic [SAMPLE_W-1:0] sv, logic [IDX_W-1:0] sel,
			bit typed, moments_t want);
		moments_t pred;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		sample_value <= sv;
		bin_select <= sel;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = predict_moments(rt, sv, sel);
		pending_results.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (r)
			REG_ENABLE_MASK: cfg_enable = v[4:0];
			REG_RANGE_LOW:   cfg_low = v;
			REG_INV_WIDTH:   cfg_inv = v;
			REG_BINS_IN_USE: cfg_bins = v[7:0];
		endcase
		@(negedge clk);
	endtask

	task automatic cmp_field(string fname, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			$display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_res = '{sample_count, last_sample, sum_linear, sum_squares, sum_cubes,
				bin_index, bin_hit, bin_total};
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: result with no request pending, expected none actual bin_index %0d",
					$time, bin_index);
			end else begin
				cmp_field("sample_count", pending_results[0].count, got_res.count);
				cmp_field("last_sample", pending_results[0].last, got_res.last);
				cmp_field("sum_linear", pending_results[0].sum1, got_res.sum1);
				cmp_field("sum_squares", pending_results[0].sum2, got_res.sum2);
				cmp_field("sum_cubes", pending_results[0].sum3, got_res.sum3);
				cmp_field("bin_index", pending_results[0].idx, got_res.idx);
				cmp_field("bin_hit", pending_results[0].hit, got_res.hit);
				cmp_field("bin_total", pending_results[0].total, got_res.total);
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int lim, target_bin, pick;
		longint offset;
		logic rt;
		logic [SAMPLE_W-1:0] sv, prev_sv;
		logic [IDX_W-1:0] sel;
		logic [CFG_W-1:0] cfg_word;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ENABLE_MASK;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		sample_value = '0;
		bin_select = '0;
		prev_sv = '0;
		cfg_enable = ENABLE_RST;
		cfg_low = LOW_EDGE_RST;
		cfg_inv = INV_WIDTH_RST;
		cfg_bins = BINS_RST;
		acc_count = '0;
		acc_last = '0;
		acc_sum1 = 0;
		acc_sum2 = '0;
		acc_sum3 = 0;
		foreach (hist_bins[i])
			hist_bins[i] = '0;

		// state straight after reset, then the extremes of the sample
		plan_typed(REQ_READ, 16'h0000, 7'd0, '{32'd0, 16'h0, 48'h0, 63'h0, 64'h0, 7'd0, 1'b1, 32'd0});
		plan_typed(REQ_READ, 16'h0000, 7'd127,
			'{32'd0, 16'h0, 48'h0, 63'h0, 64'h0, 7'd127, 1'b0, 32'd0});
		plan_typed(REQ_ADD, 16'h0000, 7'd0, '{32'd1, 16'h0, 48'h0, 63'h0, 64'h0, 7'd50, 1'b1, 32'd1});
		plan_typed(REQ_ADD, 16'h8000, 7'd127, '{32'd2, 16'h8000, 48'hFFFF_FFFF_8000,
			63'h4000_0000, 64'hFFFF_E000_0000_0000, 7'd0, 1'b0, 32'd0});
		plan_req(REQ_ADD, 16'h7FFF, 7'h55);
		// lower edge, just above and below half a bin under it, top bin and one past it
		plan_req(REQ_ADD, -16'sd1280, 7'h2A);
		plan_req(REQ_ADD, -16'sd1292, 7'd0);
		plan_req(REQ_ADD, -16'sd1293, 7'd0);
		plan_req(REQ_ADD, 16'sd1267, 7'd0);
		plan_req(REQ_ADD, 16'sd1268, 7'd0);
		plan_req(REQ_ADD, 16'sd1267, 7'd0);
		plan_req(REQ_READ, 16'h1234, 7'd99);
		plan_req(REQ_READ, 16'h1234, 7'd100);
		// counting goes on with everything disabled
		plan_cfg(REG_ENABLE_MASK, 16'hFFE0);
		plan_req(REQ_ADD, 16'sd12345, 7'd0);
		plan_req(REQ_READ, 16'h0, 7'd0);
		plan_cfg(REG_ENABLE_MASK, 16'h0010);
		plan_req(REQ_ADD, 16'h0000, 7'd0);
		plan_cfg(REG_ENABLE_MASK, 16'h001F);
		// zero inverse bin width puts everything in bin 0
		plan_cfg(REG_INV_WIDTH, 16'h0000);
		plan_req(REQ_ADD, 16'h8000, 7'd0);
		plan_req(REQ_ADD, 16'h7FFF, 7'd0);
		plan_cfg(REG_BINS_IN_USE, 16'h0000);
		plan_req(REQ_ADD, 16'h0000, 7'd0);
		plan_req(REQ_READ, 16'h0000, 7'd0);
		plan_cfg(REG_BINS_IN_USE, 16'h00FF);
		plan_req(REQ_READ, 16'h0000, 7'd127);
		plan_cfg(REG_RANGE_LOW, 16'h8000);
		plan_cfg(REG_INV_WIDTH, 16'hFFFF);
		plan_req(REQ_ADD, 16'h8000, 7'd0);
		plan_req(REQ_ADD, 16'h8001, 7'd0);
		plan_req(REQ_ADD, 16'h7FFF, 7'd0);
		plan_cfg(REG_BINS_IN_USE, 16'h0001);
		plan_cfg(REG_RANGE_LOW, 16'h7FFF);
		plan_cfg(REG_INV_WIDTH, 16'h0100);
		plan_req(REQ_ADD, 16'h7FFF, 7'd0);
		plan_req(REQ_ADD, 16'sd32638, 7'd0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_reg(plan[i].reg_sel, plan[i].cfg_val);
			end else begin
				send_req(plan[i].rt, plan[i].sv, plan[i].sel, plan[i].typed, plan[i].want);
			end
		end

		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			case (phase % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
				default: begin src_idle_pct = 14; sink_stall_pct = 14; end
			endcase

			// histogram mostly on; unused upper data bits random
			cfg_word = 16'($urandom);
			if ($urandom_range(3) != 0)
				cfg_word[EN_HIST] = 1'b1;
			write_reg(REG_ENABLE_MASK, cfg_word);
			cfg_word = ($urandom_range(4) == 0) ? 16'($urandom)
				: 16'(int'($urandom_range(16000)) - 12000);
			write_reg(REG_RANGE_LOW, cfg_word);
			case ($urandom_range(9))
				0: cfg_word = '0;
				1: cfg_word = '1;
				2: cfg_word = 16'($urandom);
				default: cfg_word = 16'($urandom_range(8192, 512));
			endcase
			write_reg(REG_INV_WIDTH, cfg_word);
			cfg_word = 16'($urandom);
			case ($urandom_range(7))
				0: cfg_word[7:0] = 8'd0;
				1: cfg_word[7:0] = 8'($urandom_range(255, 129));
				2: cfg_word[7:0] = 8'd128;
				default: cfg_word[7:0] = 8'($urandom_range(127, 1));
			endcase
			write_reg(REG_BINS_IN_USE, cfg_word);

			lim = (cfg_bins > MAX_BINS_DEF) ? MAX_BINS_DEF : cfg_bins;
			for (int n = 0; n < 128; n++) begin
				pick = $urandom_range(99);
				sel = 7'($urandom_range(127));
				if (pick < 20) begin
					rt = REQ_READ;
					sv = 16'($urandom);
					if (lim > 0 && $urandom_range(3) != 0)
						sel = 7'($urandom_range(lim - 1));
				end else begin
					rt = REQ_ADD;
					if (pick < 30) begin
						// same sample as the previous add again, so the same bin
						sv = prev_sv;
					end else if (pick < 45 || cfg_inv == 0) begin
						sv = 16'($urandom);
					end else begin
						// aim at a bin, a little past the top now and then
						target_bin = $urandom_range(lim + 1);
						offset = ((longint'(target_bin) <<< 16) - 32768 + $urandom_range(65535))
							/ longint'(cfg_inv);
						sv = 16'(longint'(cfg_low) + offset);
					end
					prev_sv = sv;
				end
				send_req(rt, sv, sel, 1'b0, '0);
			end
		end

		drain_results();
		repeat (20) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
